>>> rtl/triangular_band_averager_macros.svh
// Assertion macros shared by the band averager RTL.
`ifndef TRIANGULAR_BAND_AVERAGER_MACROS_SVH
`define TRIANGULAR_BAND_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held
`define TBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held
`define TBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tba_pkg.sv
// Constants, types and elaboration-time ROM contents for the band averager.
package tba_pkg;

    // Frame geometry
    localparam int NUM_BINS     = 512;
    localparam int NUM_BANDS    = 128;
    localparam int WINDOW_DEPTH = 10;

    localparam int SPAN_M = NUM_BINS - 1;
    localparam int SPAN_D = NUM_BANDS - 1;
    localparam int SPAN_W = (SPAN_M > SPAN_D) ? SPAN_M : SPAN_D;

    // Field and datapath widths
    localparam int IN_W      = 16;
    localparam int VAL_W     = 15;
    localparam int Q_W       = 16;
    localparam int VAL_MAX   = 16384;
    localparam int POS_W     = $clog2(NUM_BINS);
    localparam int BAND_W    = $clog2(NUM_BANDS);
    localparam int NEXT_W    = BAND_W + 1;
    localparam int WIN_AW    = $clog2(WINDOW_DEPTH);
    localparam int WDI_W     = $clog2(SPAN_W);
    localparam int DIST_W    = $clog2(SPAN_M * SPAN_D + 1) + 1;
    localparam int ACC_W     = VAL_W + Q_W + $clog2(WINDOW_DEPTH);
    localparam int ACC_LO_W  = 18;
    localparam int ACC_HI_W  = ACC_W - ACC_LO_W;
    localparam int PROD_LO_W = ACC_LO_W + Q_W;
    localparam int PROD_HI_W = ACC_HI_W + Q_W;
    localparam int SUM_W     = ACC_W + Q_W + 1;
    localparam int MEAN_W    = SUM_W - 32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RUN,
        S_WAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_FIN
    } t_state;

    typedef logic [Q_W-1:0]   t_weight_rom [SPAN_W];
    typedef logic [POS_W-1:0] t_pos_rom    [NUM_BANDS];
    typedef logic [Q_W-1:0]   t_recip_rom  [NUM_BANDS];

    // Last bin of band b
    function automatic longint band_end_f(longint b);
        longint e;
        e = (b * SPAN_M + SPAN_W + SPAN_D - 1) / SPAN_D;
        return (e > SPAN_M) ? longint'(SPAN_M) : e;
    endfunction

    // First bin of band b
    function automatic longint band_start_f(longint b);
        longint c;
        c = b * SPAN_M;
        return (c > SPAN_W) ? (c - SPAN_W) / SPAN_D : 64'sd0;
    endfunction

    // Q0.16 triangle weight at scaled distance d
    function automatic longint weight_f(longint d);
        longint q;
        if (d >= SPAN_W) begin
            return 0;
        end
        q = ((SPAN_W - d) * 65536 + SPAN_W / 2) / SPAN_W;
        return (q > 65535) ? 64'sd65535 : q;
    endfunction

    // round(2^32 / s) by shift-and-subtract, saturated to Q0.16
    function automatic longint recip_f(longint s);
        longint num;
        longint rem;
        longint q;
        if (s == 0) begin
            return 0;
        end
        num = (64'sd1 <<< 32) + (s >>> 1);
        rem = 0;
        q   = 0;
        for (int i = 33; i >= 0; i--) begin
            rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
            if (rem >= s) begin
                rem = rem - s;
                q   = q | (64'sd1 <<< i);
            end
        end
        return (q > 65535) ? 64'sd65535 : q;
    endfunction

    function automatic t_weight_rom weight_rom_f();
        t_weight_rom r;
        for (int d = 0; d < SPAN_W; d++) begin
            r[d] = Q_W'(weight_f(longint'(d)));
        end
        return r;
    endfunction

    function automatic t_pos_rom end_rom_f();
        t_pos_rom r;
        for (int b = 0; b < NUM_BANDS; b++) begin
            r[b] = POS_W'(band_end_f(longint'(b)));
        end
        return r;
    endfunction

    function automatic t_pos_rom start_rom_f();
        t_pos_rom r;
        for (int b = 0; b < NUM_BANDS; b++) begin
            r[b] = POS_W'(band_start_f(longint'(b)));
        end
        return r;
    endfunction

    // Reciprocal of each band's total weight
    function automatic t_recip_rom recip_rom_f();
        t_recip_rom r;
        longint     s;
        longint     x;
        longint     c;
        for (int b = 0; b < NUM_BANDS; b++) begin
            s = 0;
            c = longint'(b) * SPAN_M;
            for (longint k = band_start_f(b); k <= band_end_f(b); k++) begin
                x = k * SPAN_D;
                s = s + weight_f((x > c) ? x - c : c - x);
            end
            r[b] = Q_W'(recip_f(s));
        end
        return r;
    endfunction

    localparam t_weight_rom WEIGHT_ROM     = weight_rom_f();
    localparam t_pos_rom    BAND_END_ROM   = end_rom_f();
    localparam t_pos_rom    BAND_START_ROM = start_rom_f();
    localparam t_recip_rom  RECIP_ROM      = recip_rom_f();

endpackage

>>> rtl/triangular_band_averager.sv
// Triangular band averager: spectrum bins in, weighted band means out.
//
// Input channel (i_in_valid / o_in_ready) takes one spectrum bin word per
// handshake, in frame order, NUM_BINS bins per frame. Invalid or negative
// bins count as zero. Output channel (o_out_valid / i_out_ready) gives one
// band word per handshake: mean, band index, frame_last, run_last.
// A bin that closes a band starts one sweep per band, at most two bands per
// bin; the bands here span up to 11 bins. Each band runs on the shared
// multiply-accumulate, which takes one bin per cycle from the window memory
// and the weight ROM, then the scaling multiply in a low and a high half.
// No bin is taken while a band is computed; the band word is registered.
// Reset clears the frame position, the band counter and the handshakes;
// the window memory needs no clearing, since only bins of the current
// frame are ever read. While the receiver stalls, the finished band waits
// in the output register; the block keeps taking bins until it has a
// second band ready, then holds until the first one is taken.
`include "triangular_band_averager_macros.svh"

module triangular_band_averager
    import tba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [IN_W-1:0]  i_bin_value,
    input  logic                    i_bin_invalid,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VAL_W-1:0]        o_band_value,
    output logic [BAND_W-1:0]       o_band_index,
    output logic                    o_frame_last,
    output logic                    o_run_last
);

    // Window memory of recent bins
    logic [VAL_W-1:0]     mem [WINDOW_DEPTH];

    t_state               r_state, n_state;
    logic [WIN_AW-1:0]    r_head;
    logic [POS_W-1:0]     r_pos;
    logic [NEXT_W-1:0]    r_next;
    logic [1:0]           r_cnt;
    logic [POS_W-1:0]     r_k;
    logic [ACC_W-1:0]     r_acc;
    logic [VAL_W-1:0]     r_bin_rd;
    logic [Q_W-1:0]       r_w_rd;
    logic                 r_mac_vld;
    logic                 r_mac_use;
    logic [PROD_LO_W-1:0] r_p_lo;
    logic [PROD_HI_W-1:0] r_p_hi;
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_band_value;
    logic [BAND_W-1:0]    r_band_index;
    logic                 r_frame_last;
    logic                 r_run_last;

    logic                 accept;
    logic                 start_band;
    logic                 step_end;
    logic                 issue;
    logic                 emit;
    logic                 last_k;
    logic                 due;
    logic                 more;
    logic [BAND_W-1:0]    cur_band;
    logic [POS_W-1:0]     end_cur;
    logic [NEXT_W-1:0]    nb2;
    logic [VAL_W-1:0]     in_clip;
    logic [WIN_AW-1:0]    head_inc;
    logic [DIST_W-1:0]    dist_x;
    logic [DIST_W-1:0]    dist_c;
    logic [DIST_W-1:0]    dist_abs;
    logic                 w_hit;
    logic [POS_W-1:0]     age;
    logic [WIN_AW-1:0]    age_s;
    logic                 in_win;
    logic [WIN_AW-1:0]    rd_addr;
    logic [Q_W-1:0]       rq;
    logic [SUM_W-1:0]     sum;
    logic [MEAN_W-1:0]    mean_full;
    logic [VAL_W-1:0]     mean_sat;

    // Band bookkeeping from the constant tables
    assign cur_band = r_next[BAND_W-1:0];
    assign end_cur  = BAND_END_ROM[cur_band];
    assign due      = (r_cnt < 2'd2) && (r_next < NEXT_W'(NUM_BANDS)) && (end_cur <= r_pos);
    assign nb2      = r_next + 1'b1;
    assign more     = (nb2 < NEXT_W'(NUM_BANDS)) &&
                      (BAND_END_ROM[nb2[BAND_W-1:0]] <= r_pos);
    assign rq       = RECIP_ROM[cur_band];

    // Input clipping and window pointer
    assign in_clip  = (!i_bin_invalid && !i_bin_value[IN_W-1]) ? i_bin_value[VAL_W-1:0] : '0;
    assign head_inc = (r_head == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Distance of bin r_k from the band center, scaled by SPAN_D
    assign dist_x   = DIST_W'(r_k) * DIST_W'(SPAN_D);
    assign dist_c   = DIST_W'(cur_band) * DIST_W'(SPAN_M);
    assign dist_abs = (dist_x > dist_c) ? dist_x - dist_c : dist_c - dist_x;
    assign w_hit    = dist_abs < DIST_W'(SPAN_W);

    // Age of bin r_k and its slot in the window
    assign age     = r_pos - r_k;
    assign age_s   = age[WIN_AW-1:0];
    assign in_win  = (r_k <= r_pos) && (int'(age) < WINDOW_DEPTH);
    assign rd_addr = (r_head >= age_s) ? r_head - age_s
                                       : r_head + WIN_AW'(WINDOW_DEPTH) - age_s;

    // Final scaling, rounding and saturation
    assign sum       = (SUM_W'(r_p_hi) << ACC_LO_W) + SUM_W'(r_p_lo) + (SUM_W'(1) << 31);
    assign mean_full = sum[SUM_W-1:32];
    assign mean_sat  = (mean_full > MEAN_W'(VAL_MAX)) ? VAL_W'(VAL_MAX) : mean_full[VAL_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EVAL;
            S_EVAL:   n_state = due ? S_RUN : S_IDLE;
            S_RUN:    if (last_k) n_state = S_WAIT;
            S_WAIT:   n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_FIN;
            S_FIN:    if (!r_out_valid || i_out_ready) n_state = S_EVAL;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        accept     = 1'b0;
        start_band = 1'b0;
        step_end   = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        o_in_ready = 1'b0;
        last_k     = (r_k == end_cur);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
            end
            S_EVAL: begin
                start_band = due;
                step_end   = !due;
            end
            S_RUN:    issue = 1'b1;
            S_FIN:    emit  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_pos       <= '0;
            r_next      <= '0;
            r_cnt       <= '0;
            r_mac_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mac_vld <= issue;
            if (accept) begin
                r_head <= head_inc;
                r_cnt  <= '0;
            end
            if (step_end) begin
                if (r_pos >= POS_W'(SPAN_M)) begin
                    r_pos  <= '0;
                    r_next <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (emit) begin
                r_next <= nb2;
                r_cnt  <= r_cnt + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window memory: write on accept, registered read during the bin sweep
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[head_inc] <= in_clip;
        end
        if (issue) begin
            r_bin_rd <= mem[rd_addr];
        end
    end

    // Weight ROM read, registered
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_w_rd    <= WEIGHT_ROM[dist_abs[WDI_W-1:0]];
            r_mac_use <= w_hit && in_win;
        end
    end

    // Bin sweep, multiply-accumulate and scaling multiplies
    always_ff @(posedge i_clk) begin
        if (start_band) begin
            r_k   <= BAND_START_ROM[cur_band];
            r_acc <= '0;
        end else begin
            if (issue && !last_k) begin
                r_k <= r_k + 1'b1;
            end
            if (r_mac_vld && r_mac_use) begin
                r_acc <= r_acc + ACC_W'(r_bin_rd) * ACC_W'(r_w_rd);
            end
        end
        if (r_state == S_MUL_LO) begin
            r_p_lo <= PROD_LO_W'(r_acc[ACC_LO_W-1:0]) * PROD_LO_W'(rq);
        end
        if (r_state == S_MUL_HI) begin
            r_p_hi <= PROD_HI_W'(r_acc[ACC_W-1:ACC_LO_W]) * PROD_HI_W'(rq);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_band_value <= mean_sat;
            r_band_index <= cur_band;
            r_frame_last <= (cur_band == BAND_W'(NUM_BANDS - 1));
            r_run_last   <= (r_cnt == 2'd1) || !more;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_band_value = r_band_value;
    assign o_band_index = r_band_index;
    assign o_frame_last = r_frame_last;
    assign o_run_last   = r_run_last;

    // Checks
    `TBA_ASSERT_NOW(a_value_sat, o_out_valid, o_band_value <= VAL_W'(VAL_MAX), "band value above 1.0")
    `TBA_ASSERT_NOW(a_frame_last, o_out_valid && o_frame_last, o_band_index == BAND_W'(NUM_BANDS - 1), "frame_last on wrong band")
    `TBA_ASSERT_NEXT(a_mac_follows, r_state == S_RUN, r_mac_vld, "sweep read without accumulate")
    `TBA_ASSERT_NOW(a_sweep_range, r_state == S_RUN, r_k <= end_cur && r_k <= r_pos, "bin sweep past band end")

endmodule
